@@ hw/rtl/sbs_pkg.sv @@
// Shared types, sizes and codes for the set-of-bounded-stacks block.
// No dependencies; used by sbs_ram users and set_of_bounded_stacks_top.
package sbs_pkg;

    localparam int SUB_DEPTH   = 4;
    localparam int NUM_STACKS  = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int STORE_DEPTH = NUM_STACKS * SUB_DEPTH;

    localparam int CNT_W  = $clog2(SUB_DEPTH + 1);
    localparam int STK_W  = $clog2(NUM_STACKS);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef logic [CNT_W-1:0]               cnt_t;
    typedef logic [STK_W-1:0]               stk_t;
    typedef logic [ADDR_W-1:0]              addr_t;
    typedef logic signed [DATA_WIDTH-1:0]   data_t;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_POP_AT = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ALL_EMPTY  = 3'd1,
        ST_PAST_LAST  = 3'd2,
        ST_SUB_EMPTY  = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // slot s of sub-stack k lives at k*SUB_DEPTH + s
    function automatic addr_t slot_addr(input stk_t k, input cnt_t s);
        addr_t base;
        base = addr_t'(k) * addr_t'(SUB_DEPTH);
        return base + addr_t'(s);
    endfunction

endpackage

@@ hw/rtl/sbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/set_of_bounded_stacks_top.sv @@
// Set of bounded stacks: top level, control and fill-count registers.
// Depends on sbs_pkg and sbs_ram (value store).
//
// A row of sbs_pkg::NUM_STACKS sub-stacks of sbs_pkg::SUB_DEPTH values each
// behaves as one stack. Push (operation 0) goes onto the last open sub-stack;
// pop (1) returns the newest value, skipping and dropping empty sub-stacks
// above it; pop-at (2) takes the top of the sub-stack named by s_stack_index
// and may leave a hole. Every request yields exactly one result
// (m_status, m_popped_value). Fill counts and the last-open pointer sit in
// flip-flops, so all decisions are made in the cycle a request is accepted;
// values live in a single RAM with a registered read. A push, a refused
// operation or an unused code has its result in the cycle after acceptance,
// and the next request can be taken in that same cycle when the result is
// taken: one request per cycle for such operations. A successful pop or
// pop-at first passes through the S_READ state for the RAM read, and no
// request is taken there. Input ready is low only in S_READ or while an untaken result is held.
// The value store needs no clearing after reset: a pop only reads slots
// that a push has written.
module set_of_bounded_stacks_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_push_value,
    input  logic [2:0]  s_stack_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_popped_value
);

    // control state
    sbs_pkg::state_t state_reg, state_next;
    sbs_pkg::cnt_t   fill_reg [sbs_pkg::NUM_STACKS];
    sbs_pkg::cnt_t   fill_next [sbs_pkg::NUM_STACKS];
    sbs_pkg::stk_t   last_reg, last_next;
    logic            m_valid_reg, m_valid_next;

    // result payload
    logic [2:0]      status_reg, status_next;
    logic [31:0]     popped_reg, popped_next;

    // value store ports
    logic            wr_en, rd_en;
    sbs_pkg::addr_t  wr_addr, rd_addr;
    sbs_pkg::data_t  rd_data;

    logic            accept;

    sbs_ram #(
        .WIDTH (sbs_pkg::DATA_WIDTH),
        .DEPTH (sbs_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sbs_pkg::data_t'(signed'(s_push_value))),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register is free next cycle if empty now or drained now.
    assign s_ready = (state_reg == sbs_pkg::S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_popped_value = popped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbs_pkg::S_IDLE;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < sbs_pkg::NUM_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    always_comb begin
        sbs_pkg::cnt_t top_cnt;
        sbs_pkg::cnt_t idx_cnt;
        sbs_pkg::stk_t pick;
        sbs_pkg::stk_t idx_k;
        logic          found;
        logic          idx_bad;

        state_next   = state_reg;
        last_next    = last_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        popped_next  = popped_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        // highest non-empty sub-stack at or below the last open one
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < sbs_pkg::NUM_STACKS; i++) begin
            if (fill_reg[i] != '0 && 32'(i) <= 32'(last_reg)) begin
                found = 1'b1;
                pick  = sbs_pkg::stk_t'(i);
            end
        end

        top_cnt = fill_reg[last_reg];
        idx_k   = sbs_pkg::stk_t'(s_stack_index);
        idx_bad = (32'(s_stack_index) > 32'(last_reg))
               || (32'(s_stack_index) >= 32'(sbs_pkg::NUM_STACKS));
        idx_cnt = fill_reg[idx_k];

        case (state_reg)
            sbs_pkg::S_IDLE: begin
                if (accept) begin
                    // default: immediate result, nothing popped
                    m_valid_next = 1'b1;
                    status_next  = sbs_pkg::ST_OK;
                    popped_next  = '0;
                    case (s_operation)
                        sbs_pkg::OP_PUSH: begin
                            if (top_cnt == sbs_pkg::cnt_t'(sbs_pkg::SUB_DEPTH)) begin
                                status_next = sbs_pkg::ST_FULL;
                            end else begin
                                wr_en               = 1'b1;
                                wr_addr             = sbs_pkg::slot_addr(last_reg, top_cnt);
                                fill_next[last_reg] = top_cnt + sbs_pkg::cnt_t'(1);
                                if (top_cnt + sbs_pkg::cnt_t'(1)
                                        == sbs_pkg::cnt_t'(sbs_pkg::SUB_DEPTH)
                                    && 32'(last_reg) < 32'(sbs_pkg::NUM_STACKS - 1)) begin
                                    last_next = last_reg + sbs_pkg::stk_t'(1);
                                end
                            end
                        end
                        sbs_pkg::OP_POP: begin
                            if (!found) begin
                                status_next = sbs_pkg::ST_ALL_EMPTY;
                                last_next   = '0;
                            end else begin
                                last_next       = pick;
                                fill_next[pick] = fill_reg[pick] - sbs_pkg::cnt_t'(1);
                                rd_en           = 1'b1;
                                rd_addr         = sbs_pkg::slot_addr(pick,
                                                      fill_reg[pick] - sbs_pkg::cnt_t'(1));
                                m_valid_next    = 1'b0;
                                state_next      = sbs_pkg::S_READ;
                            end
                        end
                        sbs_pkg::OP_POP_AT: begin
                            if (idx_bad) begin
                                status_next = sbs_pkg::ST_PAST_LAST;
                            end else if (idx_cnt == '0) begin
                                status_next = sbs_pkg::ST_SUB_EMPTY;
                            end else begin
                                fill_next[idx_k] = idx_cnt - sbs_pkg::cnt_t'(1);
                                rd_en            = 1'b1;
                                rd_addr          = sbs_pkg::slot_addr(idx_k,
                                                       idx_cnt - sbs_pkg::cnt_t'(1));
                                m_valid_next     = 1'b0;
                                state_next       = sbs_pkg::S_READ;
                            end
                        end
                        default: begin
                            // unused code: ok, zero
                        end
                    endcase
                end
            end
            sbs_pkg::S_READ: begin
                // output register is empty here; load the popped value
                m_valid_next = 1'b1;
                status_next  = sbs_pkg::ST_OK;
                popped_next  = 32'(rd_data);
                state_next   = sbs_pkg::S_IDLE;
            end
            default: begin
                state_next = sbs_pkg::S_IDLE;
            end
        endcase
    end

endmodule
